// ===== hw/rtl/tfbc_pkg.sv =====
// Shared types and constants for the TDMA frame and burst counter.
// No dependencies; imported by tfbc_csr, tfbc_ctrl, tfbc_dp, the top level and tfbc_checker.
`default_nettype none

package tfbc_pkg;

   localparam int SLOTS_PER_FRAME = 8;
   localparam int COUNT_WIDTH     = 8;

   localparam int T3_MOD     = 51;
   localparam int T2_MOD     = 26;
   localparam int T2_LAST    = 25;
   localparam int T3_LAST    = 50;
   localparam int FRAME_MULT = T3_MOD * T2_MOD;

   localparam int SLOT_IW     = $clog2(SLOTS_PER_FRAME);
   localparam int TABLE_DEPTH = T3_MOD * SLOTS_PER_FRAME;
   localparam int TABLE_AW    = $clog2(TABLE_DEPTH);

   localparam int CSR_AW = 3;
   localparam logic CSR_IDX_OFFSET_STEP = 1'b0;
   localparam logic CSR_IDX_SLOT_FRAC   = 1'b1;

   localparam logic [17:0] OFFSET_STEP_RESET = 18'd65536;
   localparam logic [15:0] SLOT_FRAC_RESET   = 16'd16384;

   typedef enum logic [1:0] {
      REQ_TICK   = 2'd0,
      REQ_SET    = 2'd1,
      REQ_TABLE  = 2'd2,
      REQ_STORED = 2'd3
   } tfbc_req_kind_type;

   typedef struct packed {
      tfbc_req_kind_type req_type;
      logic [10:0]       set_t1;
      logic [4:0]        set_t2;
      logic [5:0]        set_t3;
      logic [2:0]        set_slot;
      logic [5:0]        table_row;
      logic [2:0]        table_slot;
      logic [1:0]        table_code;
      logic [7:0]        stored_count;
   } tfbc_req_type;

   typedef struct packed {
      logic [10:0] count_t1;
      logic [4:0]  count_t2;
      logic [5:0]  count_t3;
      logic [2:0]  slot_now;
      logic [21:0] frame_number;
      logic [21:0] frame_number_mod;
      logic [1:0]  burst_code;
      logic [2:0]  sample_offset;
      logic [7:0]  stored_now;
   } tfbc_rsp_type;

   typedef struct packed {
      logic clear_wr;
      logic capture;
      logic apply;
      logic frame;
      logic load;
   } tfbc_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic out_free;
   } tfbc_status_type;

endpackage

`default_nettype wire

// ===== hw/rtl/tfbc_if.sv =====
// Valid/ready channel interfaces for requests and responses.
// Standalone; field widths follow the request and response payloads.
`default_nettype none

interface tfbc_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [10:0] set_t1;
   logic [4:0]  set_t2;
   logic [5:0]  set_t3;
   logic [2:0]  set_slot;
   logic [5:0]  table_row;
   logic [2:0]  table_slot;
   logic [1:0]  table_code;
   logic [7:0]  stored_count;

   modport source (
      output valid, req_type, set_t1, set_t2, set_t3, set_slot,
             table_row, table_slot, table_code, stored_count,
      input  ready
   );
   modport sink (
      input  valid, req_type, set_t1, set_t2, set_t3, set_slot,
             table_row, table_slot, table_code, stored_count,
      output ready
   );
endinterface

interface tfbc_rsp_if;
   logic        valid;
   logic        ready;
   logic [10:0] count_t1;
   logic [4:0]  count_t2;
   logic [5:0]  count_t3;
   logic [2:0]  slot_now;
   logic [21:0] frame_number;
   logic [21:0] frame_number_mod;
   logic [1:0]  burst_code;
   logic [2:0]  sample_offset;
   logic [7:0]  stored_now;

   modport source (
      output valid, count_t1, count_t2, count_t3, slot_now, frame_number,
             frame_number_mod, burst_code, sample_offset, stored_now,
      input  ready
   );
   modport sink (
      input  valid, count_t1, count_t2, count_t3, slot_now, frame_number,
             frame_number_mod, burst_code, sample_offset, stored_now,
      output ready
   );
endinterface

`default_nettype wire

// ===== hw/rtl/tfbc_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none

module tfbc_ram #(
   parameter int Width = 2,
   parameter int Depth = 408,
   localparam int AddrWidth = $clog2(Depth)
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [AddrWidth-1:0] wr_addr,
   input  wire logic [Width-1:0]     wr_data,
   input  wire logic                 rd_en,
   input  wire logic [AddrWidth-1:0] rd_addr,
   output logic      [Width-1:0]     rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/tfbc_csr.sv =====
// APB-style configuration registers: offset step and slot bits fraction.
// Depends on tfbc_pkg.
`default_nettype none

module tfbc_csr
   import tfbc_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [CSR_AW-1:0] paddr,
   input  wire logic [31:0]       pwdata,
   output logic      [31:0]       prdata,
   output logic                   pready,
   output logic      [17:0]       offset_step,
   output logic      [15:0]       slot_bits_fraction
);

   logic [17:0] offset_step_ff;
   logic [15:0] slot_frac_ff;
   logic        wr_en;
   logic        reg_idx;

   assign wr_en   = psel && penable && pwrite;
   assign reg_idx = paddr[2];
   assign pready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_step_ff <= OFFSET_STEP_RESET;
         slot_frac_ff   <= SLOT_FRAC_RESET;
      end else if (wr_en) begin
         unique case (reg_idx)
            CSR_IDX_OFFSET_STEP: offset_step_ff <= pwdata[17:0];
            CSR_IDX_SLOT_FRAC:   slot_frac_ff   <= pwdata[15:0];
            default:             offset_step_ff <= offset_step_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         CSR_IDX_OFFSET_STEP: prdata = {14'd0, offset_step_ff};
         CSR_IDX_SLOT_FRAC:   prdata = {16'd0, slot_frac_ff};
         default:             prdata = '0;
      endcase
   end

   assign offset_step        = offset_step_ff;
   assign slot_bits_fraction = slot_frac_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/tfbc_ctrl.sv =====
// Sequencer: table clear after reset, then capture, apply, frame and
// response load for each request. Depends on tfbc_pkg.
`default_nettype none

module tfbc_ctrl
   import tfbc_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire tfbc_status_type status,
   output tfbc_cmd_type         cmd
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_APPLY,
      ST_FRAME,
      ST_OUTPUT
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff, ready_in;

   always_comb begin
      state_in = state_ff;
      ready_in = ready_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
               ready_in = 1'b1;
            end
         end
         ST_IDLE: begin
            if (req_valid && ready_ff) begin
               cmd.capture = 1'b1;
               state_in    = ST_APPLY;
               ready_in    = 1'b0;
            end
         end
         ST_APPLY: begin
            cmd.apply = 1'b1;
            state_in  = ST_FRAME;
         end
         ST_FRAME: begin
            cmd.frame = 1'b1;
            state_in  = ST_OUTPUT;
         end
         ST_OUTPUT: begin
            // hold until the response register frees up
            if (status.out_free) begin
               cmd.load = 1'b1;
               state_in = ST_IDLE;
               ready_in = 1'b1;
            end
         end
         default: begin
            state_in = ST_CLEAR;
            ready_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         ready_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
      end
   end

   assign req_ready = ready_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/tfbc_dp.sv =====
// Datapath: TDMA counters, sample offset, frame numbers, burst table and
// stored counts, response register. Depends on tfbc_pkg and tfbc_ram.
`default_nettype none

module tfbc_dp
   import tfbc_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire tfbc_cmd_type cmd,
   output tfbc_status_type   status,
   input  wire tfbc_req_type req_data,
   input  wire logic [17:0]  offset_step,
   input  wire logic [15:0]  slot_bits_fraction,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output tfbc_rsp_type      rsp_data
);

   tfbc_req_type req_ff;
   tfbc_rsp_type rsp_data_ff;
   logic         rsp_valid_ff, rsp_valid_in;

   logic [10:0] t1_ff, t1_in;
   logic [4:0]  t2_ff, t2_in;
   logic [5:0]  t3_ff, t3_in;
   logic [2:0]  slot_ff, slot_in;
   logic [15:0] frac_ff, frac_in;
   logic [2:0]  whole_ff, whole_in;

   logic [COUNT_WIDTH-1:0] stored_ff [SLOTS_PER_FRAME];
   logic [SLOT_IW-1:0]     slot_idx;

   logic [TABLE_AW-1:0] clr_addr_ff;
   logic [18:0]         tick_sum;
   logic [6:0]          diff_raw;
   logic [4:0]          diff;
   logic [21:0]         fn_comb, fn_ff;
   logic [15:0]         pos_ff;
   logic [31:0]         seed_prod;

   logic                tbl_wr_en;
   logic [TABLE_AW-1:0] tbl_wr_addr, tbl_rd_addr;
   logic [1:0]          tbl_wr_data, tbl_rd_data;
   logic [5:0]          look_row;
   logic                tbl_in_range;

   assign slot_idx = slot_ff[SLOT_IW-1:0];

   // next counter and offset state
   always_comb begin
      t1_in    = t1_ff;
      t2_in    = t2_ff;
      t3_in    = t3_ff;
      slot_in  = slot_ff;
      frac_in  = frac_ff;
      whole_in = whole_ff;
      tick_sum = 19'(frac_ff) + 19'(offset_step);
      if (cmd.apply) begin
         unique case (req_ff.req_type)
            REQ_TICK: begin
               if (int'(slot_ff) >= SLOTS_PER_FRAME - 1) begin
                  slot_in = '0;
                  if (int'(t2_ff) == T2_LAST && int'(t3_ff) == T3_LAST) begin
                     t1_in = t1_ff + 11'd1;
                  end
                  t2_in = (int'(t2_ff) == T2_LAST) ? '0 : t2_ff + 5'd1;
                  t3_in = (int'(t3_ff) == T3_LAST) ? '0 : t3_ff + 6'd1;
               end else begin
                  slot_in = slot_ff + 3'd1;
               end
               whole_in = tick_sum[18:16];
               frac_in  = tick_sum[15:0];
            end
            REQ_SET: begin
               t1_in = req_ff.set_t1;
               t2_in = (int'(req_ff.set_t2) > T2_LAST) ? 5'(T2_LAST) : req_ff.set_t2;
               t3_in = (int'(req_ff.set_t3) > T3_LAST) ? 6'(T3_LAST) : req_ff.set_t3;
               slot_in = (int'(req_ff.set_slot) >= SLOTS_PER_FRAME) ?
                         3'(SLOTS_PER_FRAME - 1) : req_ff.set_slot;
               whole_in = '0;
            end
            REQ_TABLE, REQ_STORED: begin
               whole_in = whole_ff;
            end
            default: begin
               whole_in = whole_ff;
            end
         endcase
      end
      // seed the fraction from the bit position once the multiply is in
      if (cmd.load && req_ff.req_type == REQ_SET) begin
         frac_in = seed_prod[15:0];
      end
   end

   // (T3 - T2) mod 26 on a value below three times the modulus
   always_comb begin
      diff_raw = 7'(t3_ff) + 7'(T2_MOD) - 7'(t2_ff);
      if (int'(diff_raw) >= 2 * T2_MOD) begin
         diff = 5'(diff_raw - 7'(2 * T2_MOD));
      end else if (int'(diff_raw) >= T2_MOD) begin
         diff = 5'(diff_raw - 7'(T2_MOD));
      end else begin
         diff = 5'(diff_raw);
      end
      fn_comb = 22'(FRAME_MULT * int'(t1_ff) + T3_MOD * int'(diff) + int'(t3_ff));
   end

   assign seed_prod = {16'd0, pos_ff} * {16'd0, slot_bits_fraction};

   // burst table access
   assign tbl_in_range = (int'(req_ff.table_row) < T3_MOD) &&
                         (int'(req_ff.table_slot) < SLOTS_PER_FRAME);
   assign look_row     = (slot_ff != 3'd0) ? 6'(t2_ff) : t3_ff;
   assign tbl_rd_addr  = TABLE_AW'(int'(look_row) * SLOTS_PER_FRAME + int'(slot_ff));

   always_comb begin
      tbl_wr_en   = 1'b0;
      tbl_wr_addr = clr_addr_ff;
      tbl_wr_data = 2'd0;
      if (cmd.clear_wr) begin
         tbl_wr_en = 1'b1;
      end else if (cmd.apply && req_ff.req_type == REQ_TABLE && tbl_in_range) begin
         tbl_wr_en   = 1'b1;
         tbl_wr_addr = TABLE_AW'(int'(req_ff.table_row) * SLOTS_PER_FRAME +
                                 int'(req_ff.table_slot));
         tbl_wr_data = req_ff.table_code;
      end
   end

   tfbc_ram #(
      .Width (2),
      .Depth (TABLE_DEPTH)
   ) u_tfbc_table (
      .clock   (clock),
      .wr_en   (tbl_wr_en),
      .wr_addr (tbl_wr_addr),
      .wr_data (tbl_wr_data),
      .rd_en   (cmd.frame),
      .rd_addr (tbl_rd_addr),
      .rd_data (tbl_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         t1_ff       <= '0;
         t2_ff       <= '0;
         t3_ff       <= '0;
         slot_ff     <= '0;
         frac_ff     <= '0;
         whole_ff    <= '0;
         clr_addr_ff <= '0;
         for (int i = 0; i < SLOTS_PER_FRAME; i++) begin
            stored_ff[i] <= '0;
         end
      end else begin
         t1_ff    <= t1_in;
         t2_ff    <= t2_in;
         t3_ff    <= t3_in;
         slot_ff  <= slot_in;
         frac_ff  <= frac_in;
         whole_ff <= whole_in;
         if (cmd.clear_wr) begin
            clr_addr_ff <= clr_addr_ff + TABLE_AW'(1);
         end
         if (cmd.apply && req_ff.req_type == REQ_STORED) begin
            stored_ff[slot_idx] <= COUNT_WIDTH'(32'(req_ff.stored_count));
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_data;
      end
      if (cmd.frame) begin
         fn_ff  <= fn_comb;
         pos_ff <= 16'(int'(fn_comb) * SLOTS_PER_FRAME + int'(slot_ff));
      end
      if (cmd.load) begin
         rsp_data_ff.count_t1         <= t1_ff;
         rsp_data_ff.count_t2         <= t2_ff;
         rsp_data_ff.count_t3         <= t3_ff;
         rsp_data_ff.slot_now         <= slot_ff;
         rsp_data_ff.frame_number     <= fn_ff;
         rsp_data_ff.frame_number_mod <= {t1_ff, t3_ff, t2_ff};
         rsp_data_ff.burst_code       <= tbl_rd_data;
         rsp_data_ff.sample_offset    <= whole_ff;
         rsp_data_ff.stored_now       <= 8'(32'(stored_ff[slot_idx]));
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign status.clear_last = (clr_addr_ff == TABLE_AW'(TABLE_DEPTH - 1));
   assign status.out_free   = !rsp_valid_ff || rsp_ready;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_data          = rsp_data_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/tdma_frame_burst_counter_unit.sv =====
// TDMA frame/burst counter top level. A request passes through the four-step
// sequencer (accept, apply, frame number with table read, response load); the
// next request is taken only after the response load, which waits while the
// response side still holds a previous response. After reset the burst table is
// cleared, one entry per cycle, with req.ready low; CSRs take
// writes then. Depends on tfbc_pkg, tfbc_if, tfbc_csr, tfbc_ctrl, tfbc_dp, tfbc_ram.
`default_nettype none

module tdma_frame_burst_counter_unit
   import tfbc_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   tfbc_req_if.sink               req,
   tfbc_rsp_if.source             rsp,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [CSR_AW-1:0] paddr,
   input  wire logic [31:0]       pwdata,
   output logic      [31:0]       prdata,
   output logic                   pready
);

   tfbc_cmd_type    cmd;
   tfbc_status_type status;
   tfbc_req_type    req_data;
   tfbc_rsp_type    rsp_data;
   logic [17:0]     offset_step;
   logic [15:0]     slot_bits_fraction;
   logic            rsp_valid;

   assign req_data.req_type     = tfbc_req_kind_type'(req.req_type);
   assign req_data.set_t1       = req.set_t1;
   assign req_data.set_t2       = req.set_t2;
   assign req_data.set_t3       = req.set_t3;
   assign req_data.set_slot     = req.set_slot;
   assign req_data.table_row    = req.table_row;
   assign req_data.table_slot   = req.table_slot;
   assign req_data.table_code   = req.table_code;
   assign req_data.stored_count = req.stored_count;

   tfbc_csr u_tfbc_csr (
      .clock              (clock),
      .reset              (reset),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready),
      .offset_step        (offset_step),
      .slot_bits_fraction (slot_bits_fraction)
   );

   tfbc_ctrl u_tfbc_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .status    (status),
      .cmd       (cmd)
   );

   tfbc_dp u_tfbc_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_data           (req_data),
      .offset_step        (offset_step),
      .slot_bits_fraction (slot_bits_fraction),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp.ready),
      .rsp_data           (rsp_data)
   );

   assign rsp.valid            = rsp_valid;
   assign rsp.count_t1         = rsp_data.count_t1;
   assign rsp.count_t2         = rsp_data.count_t2;
   assign rsp.count_t3         = rsp_data.count_t3;
   assign rsp.slot_now         = rsp_data.slot_now;
   assign rsp.frame_number     = rsp_data.frame_number;
   assign rsp.frame_number_mod = rsp_data.frame_number_mod;
   assign rsp.burst_code       = rsp_data.burst_code;
   assign rsp.sample_offset    = rsp_data.sample_offset;
   assign rsp.stored_now       = rsp_data.stored_now;

endmodule

`default_nettype wire

// ===== hw/rtl/tfbc_checker.sv =====
// Port-level assertions for the TDMA frame/burst counter, bound to the top.
// Depends on tfbc_pkg and tdma_frame_burst_counter_unit.
`default_nettype none

module tfbc_checker
   import tfbc_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [4:0]  rsp_count_t2,
   input wire logic [5:0]  rsp_count_t3,
   input wire logic [2:0]  rsp_slot_now,
   input wire logic [21:0] rsp_frame_number
);

   // a stalled response stays up and keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_frame_number) &&
                                  $stable(rsp_slot_now))
      else $error("stalled response dropped or changed");

   // table clear keeps requests out right after reset
   a_reset_blocks: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request ready right after reset");

   // one request in flight at a time
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request ready again right after a transaction");

   // reported position stays inside the frame structure
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> int'(rsp_count_t2) <= T2_LAST && int'(rsp_count_t3) <= T3_LAST &&
                    int'(rsp_slot_now) < SLOTS_PER_FRAME)
      else $error("response position out of range");

endmodule

bind tdma_frame_burst_counter_unit tfbc_checker u_tfbc_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req.valid),
   .req_ready        (req.ready),
   .rsp_valid        (rsp.valid),
   .rsp_ready        (rsp.ready),
   .rsp_count_t2     (rsp.count_t2),
   .rsp_count_t3     (rsp.count_t3),
   .rsp_slot_now     (rsp.slot_now),
   .rsp_frame_number (rsp.frame_number)
);

`default_nettype wire

// ===== tb/sv/tdma_frame_burst_counter_unit_test.sv =====
// Self-checking testbench for the TDMA frame and burst counter unit.
// Uses tfbc_pkg and the tfbc_req_if / tfbc_rsp_if channel interfaces; drives
// directed and random requests, writes the CSRs between phases, and checks every response.

module tdma_frame_burst_counter_unit_test;
   import tfbc_pkg::*;

   localparam int RANDOM_PER_PHASE = 106;
   localparam int HOLD_CYCLES      = 300;
   localparam int DRAIN_CYCLES     = 8;
   localparam int WATCHDOG_LIMIT   = 5000;
   localparam logic [7:0] STORED_MASK = 8'((64'd1 << COUNT_WIDTH) - 64'd1);

   typedef struct {
      tfbc_req_type item;
      bit           typed;
      tfbc_rsp_type result;
   } directed_row_type;

   logic              clock;
   logic              reset;
   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [CSR_AW-1:0] paddr;
   logic [31:0]       pwdata;
   logic [31:0]       prdata;
   logic              pready;

   tfbc_req_if req_if ();
   tfbc_rsp_if rsp_if ();

   tdma_frame_burst_counter_unit i_dut (
      .clock   (clock),
      .reset   (reset),
      .req     (req_if),
      .rsp     (rsp_if),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // Predicted block state
   logic [17:0] offset_step_cfg = OFFSET_STEP_RESET;
   logic [15:0] slot_frac_cfg   = SLOT_FRAC_RESET;
   bit [10:0]   pos_t1;
   bit [4:0]    pos_t2;
   bit [5:0]    pos_t3;
   bit [2:0]    pos_slot;
   bit [15:0]   phase_frac;
   bit [2:0]    phase_whole;
   bit [1:0]    burst_types [T3_MOD][SLOTS_PER_FRAME];
   bit [7:0]    slot_stored [SLOTS_PER_FRAME];

   tfbc_rsp_type expected_positions [$];
   int           fail_count     = 0;
   int           send_idle_pct  = 0;
   int           recv_stall_pct = 0;
   bit           hold_armed     = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [21:0] full_frame();
      return 22'(FRAME_MULT * pos_t1 + T3_MOD * ((pos_t3 + T2_MOD - pos_t2) % T2_MOD)
                 + pos_t3);
   endfunction

   function automatic tfbc_rsp_type advance_position(tfbc_req_type r);
      tfbc_rsp_type res;
      logic [18:0]  sum;
      logic [63:0]  bit_pos;
      logic [5:0]   row;
      case (r.req_type)
         REQ_TICK: begin
            if (pos_slot == 3'(SLOTS_PER_FRAME - 1)) begin
               pos_slot = 3'd0;
               if (pos_t2 == 5'(T2_LAST) && pos_t3 == 6'(T3_LAST))
                  pos_t1 = pos_t1 + 11'd1;
               pos_t2 = (pos_t2 == 5'(T2_LAST)) ? 5'd0 : pos_t2 + 5'd1;
               pos_t3 = (pos_t3 == 6'(T3_LAST)) ? 6'd0 : pos_t3 + 6'd1;
            end else begin
               pos_slot = pos_slot + 3'd1;
            end
            sum         = {3'b000, phase_frac} + {1'b0, offset_step_cfg};
            phase_whole = sum[18:16];
            phase_frac  = sum[15:0];
         end
         REQ_SET: begin
            pos_t1   = r.set_t1;
            pos_t2   = (r.set_t2 > T2_LAST) ? 5'(T2_LAST) : r.set_t2;
            pos_t3   = (r.set_t3 > T3_LAST) ? 6'(T3_LAST) : r.set_t3;
            pos_slot = (r.set_slot >= SLOTS_PER_FRAME) ? 3'(SLOTS_PER_FRAME - 1) : r.set_slot;
            bit_pos  = 64'(full_frame()) * SLOTS_PER_FRAME + 64'(pos_slot);
            phase_frac  = 16'(bit_pos * 64'(slot_frac_cfg));
            phase_whole = 3'd0;
         end
         REQ_TABLE: begin
            // drop writes outside the 51-row table
            if (r.table_row <= T3_LAST && r.table_slot < SLOTS_PER_FRAME)
               burst_types[r.table_row][r.table_slot] = r.table_code;
         end
         default: begin
            slot_stored[pos_slot] = r.stored_count & STORED_MASK;
         end
      endcase
      // slot 0 looks up by T3, the other slots by T2
      row = (pos_slot != 3'd0) ? 6'(pos_t2) : pos_t3;
      res.count_t1         = pos_t1;
      res.count_t2         = pos_t2;
      res.count_t3         = pos_t3;
      res.slot_now         = pos_slot;
      res.frame_number     = full_frame();
      res.frame_number_mod = (22'(pos_t1) << 11) + (22'(pos_t3) << 5) + 22'(pos_t2);
      res.burst_code       = burst_types[row][pos_slot];
      res.sample_offset    = phase_whole;
      res.stored_now       = slot_stored[pos_slot];
      return res;
   endfunction

   function automatic tfbc_req_type req_of(tfbc_req_kind_type kind, int a, int b, int c,
                                           int d);
      tfbc_req_type r;
      r = '0;
      r.req_type = kind;
      case (kind)
         REQ_SET: begin
            r.set_t1   = 11'(a);
            r.set_t2   = 5'(b);
            r.set_t3   = 6'(c);
            r.set_slot = 3'(d);
         end
         REQ_TABLE: begin
            r.table_row  = 6'(a);
            r.table_slot = 3'(b);
            r.table_code = 2'(c);
         end
         REQ_STORED: r.stored_count = 8'(a);
         default: ;
      endcase
      return r;
   endfunction

   function automatic tfbc_rsp_type rsp_of(int t1, int t2, int t3, int slot, int fn, int fnm,
                                           int code, int offset, int stored);
      return tfbc_rsp_type'({11'(t1), 5'(t2), 6'(t3), 3'(slot), 22'(fn), 22'(fnm), 2'(code),
                             3'(offset), 8'(stored)});
   endfunction

   function automatic tfbc_req_type random_req();
      tfbc_req_type r;
      int           pick;
      r    = $bits(tfbc_req_type)'({$urandom, $urandom});
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
         r.req_type = REQ_TICK;
      end else if (pick < 68) begin
         r.req_type = REQ_SET;
         // land near the end of a frame so the following ticks wrap T2, T3 and T1
         case ($urandom_range(0, 3))
            0: begin
               r.set_t2 = 5'(T2_LAST);
               r.set_t3 = 6'(T3_LAST);
            end
            1: r.set_t3 = 6'(T3_LAST);
            2: r.set_t2 = 5'(T2_LAST);
            default: ;
         endcase
         if ($urandom_range(0, 1) == 0)
            r.set_slot = 3'($urandom_range(SLOTS_PER_FRAME - 3, SLOTS_PER_FRAME - 1));
      end else if (pick < 88) begin
         r.req_type = REQ_TABLE;
         // aim half the writes at the entry the next tick reads
         if ($urandom_range(0, 1) == 0) begin
            r.table_row  = ($urandom_range(0, 1) == 0) ? 6'(pos_t2) : pos_t3;
            r.table_slot = pos_slot + 3'd1;
         end
      end else begin
         r.req_type = REQ_STORED;
      end
      return r;
   endfunction

   task automatic drive_request(tfbc_req_type r);
      req_if.req_type     <= r.req_type;
      req_if.set_t1       <= r.set_t1;
      req_if.set_t2       <= r.set_t2;
      req_if.set_t3       <= r.set_t3;
      req_if.set_slot     <= r.set_slot;
      req_if.table_row    <= r.table_row;
      req_if.table_slot   <= r.table_slot;
      req_if.table_code   <= r.table_code;
      req_if.stored_count <= r.stored_count;
   endtask

   task automatic send_item(tfbc_req_type item, bit typed, tfbc_rsp_type given);
      int           gap;
      tfbc_rsp_type predicted;
      gap = 0;
      while (gap < 40 && $urandom_range(0, 99) < send_idle_pct)
         gap++;
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      drive_request(item);
      do @(posedge clock); while (req_if.ready !== 1'b1);
      predicted = advance_position(item);
      expected_positions.push_back(typed ? given : predicted);
   endtask

   // Leaves psel and penable high so back-to-back writes need no idle cycle
   task automatic write_csr(logic idx, logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_AW'({idx, 2'b00});
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      if (idx == CSR_IDX_OFFSET_STEP)
         offset_step_cfg = value[17:0];
      else
         slot_frac_cfg = value[15:0];
   endtask

   task automatic wait_drained();
      while (expected_positions.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   task automatic check_position();
      tfbc_rsp_type want;
      tfbc_rsp_type got;
      got = {rsp_if.count_t1, rsp_if.count_t2, rsp_if.count_t3, rsp_if.slot_now,
             rsp_if.frame_number, rsp_if.frame_number_mod, rsp_if.burst_code,
             rsp_if.sample_offset, rsp_if.stored_now};
      if (expected_positions.size() == 0) begin
         $error("response transaction with no request outstanding");
         fail_count++;
      end else begin
         want = expected_positions.pop_front();
         check_field("count_t1", want.count_t1, got.count_t1);
         check_field("count_t2", want.count_t2, got.count_t2);
         check_field("count_t3", want.count_t3, got.count_t3);
         check_field("slot_now", want.slot_now, got.slot_now);
         check_field("frame_number", want.frame_number, got.frame_number);
         check_field("frame_number_mod", want.frame_number_mod, got.frame_number_mod);
         check_field("burst_code", want.burst_code, got.burst_code);
         check_field("sample_offset", want.sample_offset, got.sample_offset);
         check_field("stored_now", want.stored_now, got.stored_now);
      end
   endtask

   // Response side: check each transaction, then pick next cycle's ready
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
            check_position();
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else if (hold_armed) begin
            hold_armed = 1'b0;
            hold_left  = HOLD_CYCLES - 1;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
         end
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
             (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1))
            quiet = 0;
         else
            quiet++;
      end
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      directed_row_type rows [$];
      logic [31:0]      step_value;
      logic [31:0]      frac_value;

      reset   <= 1'b1;
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= '0;
      pwdata  <= '0;
      req_if.valid <= 1'b0;
      drive_request('0);

      rows.push_back(directed_row_type'{req_of(REQ_TICK, 0, 0, 0, 0), 1'b1,
                                        rsp_of(0, 0, 0, 1, 0, 0, 0, 1, 0)});
      rows.push_back(directed_row_type'{req_of(REQ_STORED, 255, 0, 0, 0), 1'b1,
                                        rsp_of(0, 0, 0, 1, 0, 0, 0, 1, 255)});
      // out-of-range T2 and T3 clamp to the last frame of the hyperframe
      rows.push_back(directed_row_type'{req_of(REQ_SET, 2047, 31, 63, 7), 1'b1,
                                        rsp_of(2047, 25, 50, 7, 2715647, 4193881, 0, 0, 0)});
      rows.push_back(directed_row_type'{req_of(REQ_TABLE, 25, 7, 3, 0), 1'b1,
                                        rsp_of(2047, 25, 50, 7, 2715647, 4193881, 3, 0, 0)});
      rows.push_back(directed_row_type'{req_of(REQ_TICK, 0, 0, 0, 0), 1'b0, '0});
      rows.push_back(directed_row_type'{req_of(REQ_TABLE, 63, 0, 3, 0), 1'b0, '0});
      rows.push_back(directed_row_type'{req_of(REQ_TABLE, 51, 0, 2, 0), 1'b0, '0});
      rows.push_back(directed_row_type'{req_of(REQ_TABLE, 0, 0, 1, 0), 1'b0, '0});
      rows.push_back(directed_row_type'{req_of(REQ_STORED, 0, 0, 0, 0), 1'b0, '0});
      rows.push_back(directed_row_type'{req_of(REQ_SET, 0, 0, 0, 0), 1'b1,
                                        rsp_of(0, 0, 0, 0, 0, 0, 1, 0, 0)});
      rows.push_back(directed_row_type'{req_of(REQ_SET, 0, 25, 0, 0), 1'b0, '0});
      rows.push_back(directed_row_type'{req_of(REQ_SET, 1024, 0, 50, 6), 1'b0, '0});
      rows.push_back(directed_row_type'{req_of(REQ_TICK, 0, 0, 0, 0), 1'b0, '0});
      rows.push_back(directed_row_type'{req_of(REQ_TICK, 0, 0, 0, 0), 1'b0, '0});
      rows.push_back(directed_row_type'{req_of(REQ_TABLE, 1, 1, 2, 0), 1'b0, '0});
      rows.push_back(directed_row_type'{req_of(REQ_TICK, 0, 0, 0, 0), 1'b0, '0});
      rows.push_back(directed_row_type'{req_of(REQ_STORED, 128, 0, 0, 0), 1'b0, '0});
      rows.push_back(directed_row_type'{req_of(REQ_TABLE, 50, 0, 3, 0), 1'b0, '0});
      rows.push_back(directed_row_type'{req_of(REQ_SET, 5, 25, 50, 0), 1'b0, '0});
      rows.push_back(directed_row_type'{req_of(REQ_SET, 7, 30, 51, 3), 1'b0, '0});
      rows.push_back(directed_row_type'{req_of(REQ_TICK, 0, 0, 0, 0), 1'b0, '0});
      rows.push_back(directed_row_type'{req_of(REQ_TICK, 0, 0, 0, 0), 1'b0, '0});

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (rows[i])
         send_item(rows[i].item, rows[i].typed, rows[i].result);
      req_if.valid <= 1'b0;

      for (int phase = 0; phase < 5; phase++) begin
         wait_drained();
         case (phase)
            0: begin
               step_value     = 32'd0;
               frac_value     = 32'd0;
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
            1: begin
               step_value     = 32'd262143;
               frac_value     = 32'd65535;
               send_idle_pct  = 55;
               recv_stall_pct = 0;
            end
            2: begin
               step_value     = $urandom_range(0, 262143);
               frac_value     = $urandom_range(0, 65535);
               send_idle_pct  = 0;
               recv_stall_pct = 55;
            end
            3: begin
               step_value     = $urandom_range(0, 262143);
               frac_value     = $urandom_range(0, 65535);
               send_idle_pct  = 30;
               recv_stall_pct = 30;
            end
            default: begin
               step_value     = $urandom_range(0, 262143);
               frac_value     = $urandom_range(0, 65535);
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
         endcase
         write_csr(CSR_IDX_OFFSET_STEP, step_value);
         write_csr(CSR_IDX_SLOT_FRAC, frac_value);
         psel    <= 1'b0;
         penable <= 1'b0;
         pwrite  <= 1'b0;
         // last phase: back-pressure long enough to fill the block and stall requests
         if (phase == 4)
            hold_armed = 1'b1;
         repeat (RANDOM_PER_PHASE)
            send_item(random_req(), 1'b0, '0);
         req_if.valid <= 1'b0;
      end

      wait_drained();
      if (fail_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
